>>> rtl/core/assert_macros.svh
// Assertion macros shared by the decoder RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Implication checked in the cycle after the antecedent, outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`else

`define ASSERT_IMPL(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/core/jsu_pkg.sv
// Shared types and codes of the JSON string unescape decoder.
// No dependencies.
`timescale 1ns / 1ps

package jsu_pkg;

	localparam int unsigned MAX_RESULTS = 5;
	localparam int unsigned IDX_W = 3;

	// decode modes
	localparam logic [3:0] MODE_IDLE = 4'd0;
	localparam logic [3:0] MODE_SKIP = 4'd1;
	localparam logic [3:0] MODE_STR  = 4'd2;
	localparam logic [3:0] MODE_ESC  = 4'd3;
	localparam logic [3:0] MODE_HEX1 = 4'd4;
	localparam logic [3:0] MODE_SURB = 4'd5;
	localparam logic [3:0] MODE_SURU = 4'd6;
	localparam logic [3:0] MODE_HEX2 = 4'd7;

	// result status codes
	localparam logic [2:0] ST_DATA   = 3'd0;
	localparam logic [2:0] ST_DONE   = 3'd1;
	localparam logic [2:0] ST_NOQUOT = 3'd2;
	localparam logic [2:0] ST_BADESC = 3'd3;
	localparam logic [2:0] ST_BADHEX = 3'd4;
	localparam logic [2:0] ST_BADSUR = 3'd5;
	localparam logic [2:0] ST_UNTERM = 3'd6;

	// all results caused by one input byte
	typedef struct packed {
		logic [MAX_RESULTS-1:0][7:0] data;
		logic [MAX_RESULTS-1:0][2:0] status;
		logic [IDX_W-1:0]            count;
	} jsu_burst_t;

endpackage

>>> rtl/core/jsu_in_if.sv
// Input channel of the decoder: one raw text byte per transaction.
// No dependencies.
`timescale 1ns / 1ps

interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_final;

	modport source (output valid, output in_byte, output in_final, input ready);
	modport sink (input valid, input in_byte, input in_final, output ready);
endinterface

>>> rtl/core/jsu_out_if.sv
// Output channel of the decoder: one decoded byte or status per transaction.
// No dependencies.
`timescale 1ns / 1ps

interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [2:0] out_status;
	logic       out_end;

	modport source (output valid, output out_byte, output out_status, output out_end,
		input ready);
	modport sink (input valid, input out_byte, input out_status, input out_end,
		output ready);
endinterface

>>> rtl/core/json_string_unescape_decoder_core.sv
// Each accepted byte is held in the input register, decoded combinationally
// and its burst loaded into the result register, which offers its results.
// Throughput: one byte per cycle while each byte yields at most one result and
// the output channel takes each result; a byte that yields several results
// (up to five) holds the result register until its last result leaves, and intake stalls.
// Reset clears the valid flags of both stages and the decode state (waiting for an
// opening quote). Depends on jsu_pkg, jsu_in_if, jsu_out_if.
`timescale 1ns / 1ps

module json_string_unescape_decoder_core (
	input  logic      clk,
	input  logic      arst_n,
	jsu_in_if.sink    text,
	jsu_out_if.source decoded
);
	import jsu_pkg::*;

	jsu_burst_t burst;
	logic       burst_load;
	logic       burst_free;

	// decode each accepted byte into a burst of results
	jsu_decoder u_decoder (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text),
		.burst_free (burst_free),
		.burst_load (burst_load),
		.burst      (burst)
	);

	// serialize the burst onto the output channel
	jsu_burst_buffer u_buffer (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (burst_load),
		.burst   (burst),
		.free    (burst_free),
		.decoded (decoded)
	);

endmodule

>>> rtl/core/jsu_decoder.sv
// Input register, decode state and single-pass decode of one byte into a burst.
// Depends on jsu_pkg, jsu_in_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jsu_decoder (
	input  logic               clk,
	input  logic               arst_n,
	jsu_in_if.sink             text,
	input  logic               burst_free,
	output logic               burst_load,
	output jsu_pkg::jsu_burst_t burst
);
	import jsu_pkg::*;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;

	typedef struct packed {
		logic [2:0]      count;
		logic [3:0][7:0] data;
	} utf8_t;

	// encode a code point as UTF-8
	function automatic utf8_t utf8_encode(input logic [20:0] cp);
		utf8_t r;
		r = '0;
		if (cp <= 21'h7F) begin
			r.count   = 3'd1;
			r.data[0] = cp[7:0];
		end else if (cp <= 21'h7FF) begin
			r.count   = 3'd2;
			r.data[0] = 8'hC0 | {3'b000, cp[10:6]};
			r.data[1] = 8'h80 | {2'b00, cp[5:0]};
		end else if (cp <= 21'hFFFF) begin
			r.count   = 3'd3;
			r.data[0] = 8'hE0 | {4'b0000, cp[15:12]};
			r.data[1] = 8'h80 | {2'b00, cp[11:6]};
			r.data[2] = 8'h80 | {2'b00, cp[5:0]};
		end else begin
			r.count   = 3'd4;
			r.data[0] = 8'hF0 | {5'b00000, cp[20:18]};
			r.data[1] = 8'h80 | {2'b00, cp[17:12]};
			r.data[2] = 8'h80 | {2'b00, cp[11:6]};
			r.data[3] = 8'h80 | {2'b00, cp[5:0]};
		end
		return r;
	endfunction

	// map a simple escape letter; bit 8 flags a known letter
	function automatic logic [8:0] esc_map(input logic [7:0] c);
		logic [8:0] m;
		unique case (c)
			8'h22:   m = {1'b1, 8'h22};
			8'h5C:   m = {1'b1, 8'h5C};
			8'h2F:   m = {1'b1, 8'h2F};
			8'h62:   m = {1'b1, 8'h08};
			8'h66:   m = {1'b1, 8'h0C};
			8'h6E:   m = {1'b1, 8'h0A};
			8'h72:   m = {1'b1, 8'h0D};
			8'h74:   m = {1'b1, 8'h09};
			default: m = {1'b0, 8'h00};
		endcase
		return m;
	endfunction

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        final_s1;
	logic [3:0]  mode_q, mode_d;
	logic [15:0] acc_q, acc_d;
	logic [9:0]  high_q, high_d;
	logic [1:0]  dcnt_q, dcnt_d;

	logic        advance;
	logic        dig_ok;
	logic [3:0]  dig;
	logic [15:0] acc_shift;
	logic [20:0] cp_pair;
	logic [8:0]  esc;
	utf8_t       enc;
	logic [2:0]  m_cnt;
	logic [3:0][7:0] m_data;
	logic [3:0][2:0] m_st;
	logic        f_en;
	logic [2:0]  f_st;

	// hex digit value of the current byte
	always_comb begin
		dig_ok = 1'b1;
		dig    = 4'd0;
		priority if (byte_s1 >= 8'h30 && byte_s1 <= 8'h39) begin
			dig = byte_s1[3:0];
		end else if ((byte_s1 >= 8'h61 && byte_s1 <= 8'h66) ||
		             (byte_s1 >= 8'h41 && byte_s1 <= 8'h46)) begin
			dig = byte_s1[3:0] + 4'd9;
		end else begin
			dig_ok = 1'b0;
		end
	end

	assign acc_shift = {acc_q[11:0], dig};
	assign cp_pair   = 21'h10000 + {1'b0, high_q, acc_shift[9:0]};
	assign esc       = esc_map(byte_s1);

	// decode one byte against the current mode
	always_comb begin
		mode_d = mode_q;
		acc_d  = acc_q;
		high_d = high_q;
		dcnt_d = dcnt_q;
		m_cnt  = 3'd0;
		m_data = '0;
		m_st   = '0;
		enc    = '0;
		f_en   = 1'b0;
		f_st   = ST_DATA;
		unique case (mode_q)
			MODE_STR: begin
				priority if (byte_s1 == CH_QUOTE) begin
					m_cnt   = 3'd1;
					m_st[0] = ST_DONE;
					mode_d  = MODE_IDLE;
				end else if (byte_s1 == CH_BSLASH) begin
					mode_d = MODE_ESC;
				end else begin
					m_cnt     = 3'd1;
					m_data[0] = byte_s1;
				end
			end
			MODE_ESC: begin
				priority if (esc[8]) begin
					m_cnt     = 3'd1;
					m_data[0] = esc[7:0];
					mode_d    = MODE_STR;
				end else if (byte_s1 == CH_U) begin
					acc_d  = '0;
					dcnt_d = '0;
					mode_d = MODE_HEX1;
				end else begin
					m_cnt   = 3'd1;
					m_st[0] = ST_BADESC;
					mode_d  = MODE_SKIP;
				end
			end
			MODE_HEX1: begin
				priority if (!dig_ok) begin
					m_cnt   = 3'd1;
					m_st[0] = ST_BADHEX;
					mode_d  = MODE_SKIP;
				end else if (dcnt_q == 2'd3) begin
					acc_d  = acc_shift;
					dcnt_d = 2'd0;
					if (acc_shift >= 16'hD800 && acc_shift <= 16'hDBFF) begin
						high_d = acc_shift[9:0];
						mode_d = MODE_SURB;
					end else begin
						enc    = utf8_encode({5'd0, acc_shift});
						m_cnt  = enc.count;
						m_data = enc.data;
						mode_d = MODE_STR;
					end
				end else begin
					acc_d  = acc_shift;
					dcnt_d = dcnt_q + 2'd1;
				end
			end
			MODE_SURB: begin
				if (byte_s1 == CH_BSLASH) begin
					mode_d = MODE_SURU;
				end else begin
					m_cnt   = 3'd1;
					m_st[0] = ST_BADSUR;
					mode_d  = MODE_SKIP;
				end
			end
			MODE_SURU: begin
				if (byte_s1 == CH_U) begin
					acc_d  = '0;
					dcnt_d = '0;
					mode_d = MODE_HEX2;
				end else begin
					m_cnt   = 3'd1;
					m_st[0] = ST_BADSUR;
					mode_d  = MODE_SKIP;
				end
			end
			MODE_HEX2: begin
				priority if (!dig_ok) begin
					m_cnt   = 3'd1;
					m_st[0] = ST_BADHEX;
					mode_d  = MODE_SKIP;
				end else if (dcnt_q == 2'd3) begin
					acc_d  = acc_shift;
					dcnt_d = 2'd0;
					if (acc_shift >= 16'hDC00 && acc_shift <= 16'hDFFF) begin
						enc    = utf8_encode(cp_pair);
						m_cnt  = enc.count;
						m_data = enc.data;
						mode_d = MODE_STR;
					end else begin
						m_cnt   = 3'd1;
						m_st[0] = ST_BADSUR;
						mode_d  = MODE_SKIP;
					end
				end else begin
					acc_d  = acc_shift;
					dcnt_d = dcnt_q + 2'd1;
				end
			end
			MODE_SKIP: begin
				if (byte_s1 == CH_QUOTE) begin
					mode_d = MODE_STR;
				end
			end
			default: begin
				if (byte_s1 == CH_QUOTE) begin
					mode_d = MODE_STR;
				end else begin
					m_cnt   = 3'd1;
					m_st[0] = ST_NOQUOT;
					mode_d  = MODE_SKIP;
				end
			end
		endcase

		// close the text on the last byte
		if (final_s1) begin
			unique case (mode_d)
				MODE_STR: begin
					f_en = 1'b1;
					f_st = ST_UNTERM;
				end
				MODE_ESC: begin
					f_en = 1'b1;
					f_st = ST_BADESC;
				end
				MODE_HEX1, MODE_HEX2: begin
					f_en = 1'b1;
					f_st = ST_BADHEX;
				end
				MODE_SURB, MODE_SURU: begin
					f_en = 1'b1;
					f_st = ST_BADSUR;
				end
				default: begin
					f_en = 1'b0;
				end
			endcase
			mode_d = MODE_IDLE;
			acc_d  = '0;
			dcnt_d = '0;
		end
	end

	// assemble the burst: main results, then the closing status
	always_comb begin
		burst = '0;
		for (int i = 0; i < 4; i++) begin
			if (IDX_W'(i) < m_cnt) begin
				burst.data[i]   = m_data[i];
				burst.status[i] = m_st[i];
			end
		end
		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (f_en && IDX_W'(i) == m_cnt) begin
				burst.status[i] = f_st;
			end
		end
		burst.count = m_cnt + {2'b00, f_en};
	end

	// hand the burst over when the output side can take it
	assign advance    = valid_s1 && (burst.count == '0 || burst_free);
	assign burst_load = advance && burst.count != '0;
	assign text.ready = !valid_s1 || advance;

	// hold the accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			byte_s1  <= text.in_byte;
			final_s1 <= text.in_final;
		end
	end

	// advance the decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			acc_q  <= '0;
			high_q <= '0;
			dcnt_q <= '0;
		end else if (advance) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			high_q <= high_d;
			dcnt_q <= dcnt_d;
		end
	end

	`ASSERT_NEXT(a_final_idle, advance && final_s1, mode_q == MODE_IDLE, "final byte left a string open")
	`ASSERT_IMPL(a_count_max, advance, burst.count <= IDX_W'(MAX_RESULTS), "burst too long")
	`ASSERT_NEXT(a_in_hold, valid_s1 && !advance, valid_s1 && $stable(byte_s1), "stalled byte moved")

endmodule

>>> rtl/core/jsu_burst_buffer.sv
// Result register that holds one burst and sends it out one result at a time.
// Depends on jsu_pkg, jsu_out_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jsu_burst_buffer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  jsu_pkg::jsu_burst_t burst,
	output logic                free,
	jsu_out_if.source           decoded
);
	import jsu_pkg::*;

	jsu_burst_t       burst_q;
	logic             valid_q;
	logic [IDX_W-1:0] idx_q;
	logic             last;

	assign last = (idx_q == burst_q.count - IDX_W'(1));
	assign free = !valid_q || (last && decoded.ready);

	assign decoded.valid      = valid_q;
	assign decoded.out_byte   = burst_q.data[idx_q];
	assign decoded.out_status = burst_q.status[idx_q];
	assign decoded.out_end    = last;

	// step through the burst, reload when the last result goes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && decoded.ready) begin
			if (last) begin
				valid_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// hold the burst payload
	always_ff @(posedge clk) begin
		if (load) begin
			burst_q <= burst;
		end
	end

	`ASSERT_IMPL(a_load_free, load, free, "burst loaded over a pending one")
	`ASSERT_IMPL(a_load_nonempty, load, burst.count != '0, "empty burst loaded")
	`ASSERT_IMPL(a_idx_range, valid_q, idx_q < burst_q.count, "result index past burst")
	`ASSERT_NEXT(a_stall_hold, valid_q && !decoded.ready, valid_q && $stable(idx_q), "stalled result moved")

endmodule
